/* src/kms_pkg.sv */
// Shared types and constants for the keypad matrix scanner.
// No dependencies; imported by every other module of the block except kms_ram.
package kms_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_QUEUE = 2'd0;
    localparam logic [1:0] KIND_GROUP = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_APPLY = 2'd3;

    // Configuration port
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IRQ_EN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ON_CODE = 4'd1;

    localparam logic [6:0] ON_CODE_RESET = 7'd41;
    localparam logic [6:0] KEY_CODE_MAX  = 7'd64;
    localparam logic [7:0] GROUP_RESET   = 8'hFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key_code;
        logic [7:0] group_value;
    } kms_in_t;

    typedef struct packed {
        logic [7:0] key_bits;
        logic       on_interrupt;
        logic       on_key_down;
        logic       dropped;
    } kms_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic queue;
        logic set_group;
        logic apply_item;
        logic read_step;
        logic apply_pop;
        logic scan_load;
        logic scan_step;
        logic out_load;
    } kms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       pop_now;
        logic       scan_done;
        logic       out_free;
    } kms_stat_t;

endpackage

/* src/kms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kms_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/kms_datapath.sv */
// Datapath of the keypad scanner: key matrix, group mask, ON key, event queue,
// ghosting closure and result register. Depends on kms_pkg and kms_ram.
module kms_datapath
    import kms_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH   = 32,
    parameter int unsigned POP_INTERVAL = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kms_in_t               s_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  kms_cmd_t              cmd,
    output kms_stat_t             stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kms_out_t              m_data
);

    localparam int unsigned AW     = $clog2(FIFO_DEPTH);
    localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned CNT_W  = (POP_INTERVAL > 1) ? $clog2(POP_INTERVAL) : 1;

    kms_in_t           item_reg;
    logic [7:0]        rows_reg [8];
    logic [7:0]        group_reg;
    logic              held_reg;
    logic              irq_en_reg;
    logic [6:0]        on_code_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     tail_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [7:0]        keys_reg;
    logic              pulse_reg;
    logic              dropped_reg;
    logic              m_valid_reg;
    kms_out_t          m_data_reg;

    logic              full;
    logic              pop_now;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_rdata;

    logic              apply_en;
    logic [7:0]        ev;
    logic [6:0]        ev_code;
    logic              ev_rel;
    logic              ev_is_on;
    logic              ev_in_range;
    logic [6:0]        key_lin;
    logic [5:0]        key_idx;

    logic [7:0]        sel_or;
    logic [7:0]        grow;

    assign full = (fill_reg == FILL_W'(FIFO_DEPTH));

    assign cnt_next = (cnt_reg == CNT_W'(POP_INTERVAL - 1)) ? '0 : cnt_reg + 1'b1;
    assign pop_now  = (cnt_next == '0) && (fill_reg != '0);

    assign ram_we = cmd.queue && !full;
    assign ram_re = cmd.read_step && pop_now;

    kms_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (item_reg.key_code),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Event decode, shared by immediate events and events popped from the queue
    assign apply_en    = cmd.apply_item || cmd.apply_pop;
    assign ev          = cmd.apply_pop ? ram_rdata : item_reg.key_code;
    assign ev_code     = ev[6:0];
    assign ev_rel      = ev[7];
    assign ev_is_on    = (ev_code == on_code_reg);
    assign ev_in_range = (ev_code != 7'd0) && (ev_code <= KEY_CODE_MAX);
    assign key_lin     = ev_code - 7'd1;
    assign key_idx     = key_lin[5:0];

    // Ghosting: one parallel pass of the closure per cycle
    always_comb begin
        sel_or = '0;
        grow   = keys_reg;
        for (int r = 0; r < 8; r++) begin
            if (!group_reg[r]) begin
                sel_or = sel_or | rows_reg[r];
            end
            if ((keys_reg & rows_reg[r]) != 8'd0) begin
                grow = grow | rows_reg[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 8; r++) begin
                rows_reg[r] <= '0;
            end
        end else if (apply_en && !ev_is_on && ev_in_range) begin
            for (int r = 0; r < 8; r++) begin
                if (key_idx[5:3] == 3'(r)) begin
                    rows_reg[r][key_idx[2:0]] <= !ev_rel;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg   <= GROUP_RESET;
            held_reg    <= 1'b0;
            irq_en_reg  <= 1'b0;
            on_code_reg <= ON_CODE_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_IDX_IRQ_EN:  irq_en_reg  <= cfg_data[0];
                    CFG_IDX_ON_CODE: on_code_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (cmd.set_group) begin
                group_reg <= item_reg.group_value;
            end
            if (apply_en && ev_is_on) begin
                held_reg <= !ev_rel;
            end
            if (ram_we) begin
                tail_reg <= (tail_reg == AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.read_step) begin
                cnt_reg <= cnt_next;
            end
            if (ram_re) begin
                head_reg <= (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg    <= s_data;
            keys_reg    <= '0;
            pulse_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end else begin
            if (cmd.queue && full) begin
                dropped_reg <= 1'b1;
            end
            if (apply_en && ev_is_on) begin
                pulse_reg <= irq_en_reg && (ev_rel ? held_reg : !held_reg);
            end
            if (cmd.scan_load) begin
                keys_reg <= sel_or;
            end else if (cmd.scan_step) begin
                keys_reg <= grow;
            end
        end
        if (cmd.out_load) begin
            m_data_reg.key_bits     <= (item_reg.kind == KIND_READ) ? ~keys_reg : 8'd0;
            m_data_reg.on_interrupt <= pulse_reg;
            m_data_reg.on_key_down  <= held_reg;
            m_data_reg.dropped      <= dropped_reg;
        end
    end

    assign stat.kind      = item_reg.kind;
    assign stat.pop_now   = pop_now;
    assign stat.scan_done = (grow == keys_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(FIFO_DEPTH))
        else $error("queue fill count above depth");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == tail_reg) == ((fill_reg == '0) || full))
        else $error("queue pointers disagree with fill count");

    a_pop_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply_pop |-> $past(ram_re))
        else $error("popped event applied without a queue read");

    a_no_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("queue written and read by the same item");
`endif

endmodule

/* src/kms_ctrl.sv */
// Controller of the keypad scanner: sequences one item at a time through
// execute and result load; a read also passes an event pop when one is due and the ghosting scan. Depends on kms_pkg.
module kms_ctrl
    import kms_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  kms_stat_t stat,
    output kms_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_EXEC      = 3'd1;
    localparam logic [2:0] ST_APPLY     = 3'd2;
    localparam logic [2:0] ST_SCAN_LOAD = 3'd3;
    localparam logic [2:0] ST_SCAN_STEP = 3'd4;
    localparam logic [2:0] ST_FINISH    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
                unique case (stat.kind)
                    KIND_QUEUE: cmd.queue      = 1'b1;
                    KIND_GROUP: cmd.set_group  = 1'b1;
                    KIND_APPLY: cmd.apply_item = 1'b1;
                    KIND_READ: begin
                        cmd.read_step = 1'b1;
                        state_next    = stat.pop_now ? ST_APPLY : ST_SCAN_LOAD;
                    end
                    default: ;
                endcase
            end
            ST_APPLY: begin
                cmd.apply_pop = 1'b1;
                state_next    = ST_SCAN_LOAD;
            end
            ST_SCAN_LOAD: begin
                cmd.scan_load = 1'b1;
                state_next    = ST_SCAN_STEP;
            end
            ST_SCAN_STEP: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten before transfer");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in work");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> s_ready)
        else $error("controller not idle after result load");
`endif

endmodule

/* src/key_matrix_scanner_with_event_fifo.sv */
// Keypad matrix scanner: 8x8 key matrix with group select, ON key, event queue
// and ghosting. One item is in work at a time; a finished result waits in the
// output register while the next item is taken. Queue, group-mask and
// immediate-event items go through execute and result load only. A read also
// passes an apply step when it pops a queued event (the queue RAM read is
// registered), and the ghosting closure, which makes one parallel pass over
// the eight rows per cycle until nothing grows. Configuration writes are
// always accepted. Depends on kms_pkg, kms_ctrl, kms_datapath and kms_ram.
module key_matrix_scanner_with_event_fifo
    import kms_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH   = 32,
    parameter int unsigned POP_INTERVAL = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kms_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kms_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    kms_cmd_t  cmd;
    kms_stat_t stat;

    assign cfg_ready = 1'b1;

    kms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kms_datapath #(
        .FIFO_DEPTH   (FIFO_DEPTH),
        .POP_INTERVAL (POP_INTERVAL)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* tb/key_matrix_scanner_with_event_fifo_tb.sv */
// Self-checking testbench for key_matrix_scanner_with_event_fifo: directed and random
// keypad traffic, a cycle-free predictor of the key matrix, event queue and ON key.
// Depends on kms_pkg and the key_matrix_scanner_with_event_fifo RTL.
module key_matrix_scanner_with_event_fifo_tb;
    import kms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned EVQ_DEPTH     = 32;
    localparam int unsigned READS_PER_POP = 10;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned PHASE_ITEMS   = 300;
    localparam longint      TIMEOUT_NS    = 5_000_000;

    // indexes past the end of the register list, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 4'd15;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    kms_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    kms_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    key_matrix_scanner_with_event_fifo #(
        .FIFO_DEPTH   (EVQ_DEPTH),
        .POP_INTERVAL (READS_PER_POP)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Keypad state as the block should hold it
    logic [7:0] key_matrix [8]         = '{default: 8'h00};
    logic [7:0] grp_sel                = GROUP_RESET;
    logic       on_held                = 1'b0;
    logic [7:0] evq [EVQ_DEPTH]        = '{default: 8'h00};
    logic [4:0] evq_rd                 = '0;
    logic [4:0] evq_wr                 = '0;
    int unsigned evq_count             = 0;
    int unsigned read_tick             = 0;
    logic       irq_en                 = 1'b0;
    logic [6:0] on_code                = ON_CODE_RESET;

    kms_in_t  pending [$];
    kms_out_t expected_q [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_go        = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned fail_count     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Applies one key event to the matrix or the ON key, returns the interrupt pulse
    function automatic logic apply_key_event(logic [7:0] ev);
        logic [6:0] code;
        logic [6:0] pos;
        logic       pulse;
        code  = ev[6:0];
        pulse = 1'b0;
        if (code == on_code) begin
            pulse   = irq_en && (on_held == ev[7]);
            on_held = !ev[7];
        end else if (code >= 7'd1 && code <= KEY_CODE_MAX) begin
            pos = code - 7'd1;
            key_matrix[pos[5:3]][pos[2:0]] = !ev[7];
        end
        return pulse;
    endfunction

    // OR of the selected rows, grown across rows that share a column
    function automatic logic [7:0] scan_matrix();
        logic [7:0] cols;
        logic [7:0] prev;
        int r;
        cols = '0;
        for (r = 0; r < 8; r++)
            if (!grp_sel[r]) cols |= key_matrix[r];
        do begin
            prev = cols;
            for (r = 0; r < 8; r++)
                if ((cols & key_matrix[r]) != 8'h00) cols |= key_matrix[r];
        end while (cols != prev);
        return ~cols;
    endfunction

    function automatic kms_out_t keypad_step(kms_in_t it);
        kms_out_t res;
        res = '0;
        case (it.kind)
            KIND_QUEUE: begin
                if (evq_count < EVQ_DEPTH) begin
                    evq[evq_wr] = it.key_code;
                    evq_wr      = evq_wr + 5'd1;
                    evq_count++;
                end else begin
                    res.dropped = 1'b1;
                end
            end
            KIND_GROUP: grp_sel = it.group_value;
            KIND_READ: begin
                read_tick = (read_tick == READS_PER_POP - 1) ? 0 : read_tick + 1;
                if (read_tick == 0 && evq_count != 0) begin
                    res.on_interrupt = apply_key_event(evq[evq_rd]);
                    evq_rd = evq_rd + 5'd1;
                    evq_count--;
                end
                res.key_bits = scan_matrix();
            end
            default: res.on_interrupt = apply_key_event(it.key_code);
        endcase
        res.on_key_down = on_held;
        return res;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    // Input driver: offers queued items, predicts each one on its transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_q.push_back(keypad_step(s_data));
            if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by a pulse on hold_go
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge aclk) begin : result_check
        kms_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result %h", m_data);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("key_bits", want.key_bits, m_data.key_bits);
                    check_field("on_interrupt", 8'(want.on_interrupt),
                                8'(m_data.on_interrupt));
                    check_field("on_key_down", 8'(want.on_key_down),
                                8'(m_data.on_key_down));
                    check_field("dropped", 8'(want.dropped), 8'(m_data.dropped));
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDX_IRQ_EN) irq_en = val[0];
        else if (idx == CFG_IDX_ON_CODE) on_code = val[6:0];
    endtask

    task automatic push_item(input logic [1:0] kind, input logic [7:0] code,
                             input logic [7:0] grp);
        kms_in_t it;
        it.kind        = kind;
        it.key_code    = code;
        it.group_value = grp;
        pending.push_back(it);
    endtask

    // Mostly presses and releases around a moving focus, some stray codes and ON key
    function automatic logic [7:0] rand_event(logic [6:0] focus);
        int unsigned roll;
        logic [6:0]  code;
        logic        rel;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            code = 7'((int'(focus) - 1 + $urandom_range(0, 11)) % 64 + 1);
            rel  = $urandom_range(0, 99) < 75;
        end else if (roll < 80) begin
            code = 7'($urandom_range(0, 127));
            rel  = $urandom_range(0, 99) < 75;
        end else begin
            code = on_code;
            rel  = 1'($urandom_range(0, 1));
        end
        return {rel, code};
    endfunction

    task automatic make_random_items(input int unsigned count);
        int unsigned n;
        int unsigned roll;
        int unsigned queue_pct;
        logic [6:0]  focus;
        logic [1:0]  kind;
        queue_pct = 20;
        focus     = 7'd1;
        for (n = 0; n < count; n++) begin
            // queue-heavy batches overrun the event queue, light ones drain it
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: queue_pct = 5;
                    1: queue_pct = 20;
                    default: queue_pct = 45;
                endcase
                focus = 7'($urandom_range(1, 64));
            end
            roll = $urandom_range(0, 99);
            if (roll < queue_pct) kind = KIND_QUEUE;
            else if (roll < queue_pct + 15) kind = KIND_GROUP;
            else if (roll < queue_pct + 35) kind = KIND_APPLY;
            else kind = KIND_READ;
            push_item(kind, rand_event(focus), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending.size() != 0 || s_valid || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : sequencer
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // ON code stays at its reset value here
        write_reg(CFG_IDX_IRQ_EN, 8'h01);
        push_item(KIND_READ,  8'($urandom), 8'($urandom));  // empty queue, no rows
        push_item(KIND_GROUP, 8'($urandom), 8'h00);
        push_item(KIND_APPLY, 8'h01, 8'($urandom));         // lowest matrix key
        push_item(KIND_APPLY, 8'h40, 8'($urandom));         // highest matrix key
        push_item(KIND_APPLY, 8'h00, 8'($urandom));         // out of range codes
        push_item(KIND_APPLY, 8'h41, 8'($urandom));
        push_item(KIND_APPLY, 8'h7F, 8'($urandom));
        push_item(KIND_READ,  8'($urandom), 8'($urandom));
        push_item(KIND_APPLY, 8'h29, 8'($urandom));         // ON press, then again
        push_item(KIND_APPLY, 8'h29, 8'($urandom));
        push_item(KIND_APPLY, 8'hA9, 8'($urandom));         // ON release, then again
        push_item(KIND_APPLY, 8'hA9, 8'($urandom));
        push_item(KIND_APPLY, 8'h09, 8'($urandom));
        push_item(KIND_APPLY, 8'h0A, 8'($urandom));
        push_item(KIND_GROUP, 8'($urandom), 8'hFE);         // row 0 only: ghosts into row 1
        push_item(KIND_READ,  8'($urandom), 8'($urandom));
        push_item(KIND_QUEUE, 8'h81, 8'($urandom));
        push_item(KIND_QUEUE, 8'hC0, 8'($urandom));
        push_item(KIND_QUEUE, 8'hFF, 8'($urandom));
        repeat (7) push_item(KIND_READ, 8'($urandom), 8'($urandom));  // tenth read pops
        make_random_items(PHASE_ITEMS);
        wait_idle();

        // ON code 0 via masked data, interrupts off, sender idling
        write_reg(CFG_IDX_IRQ_EN, 8'h00);
        write_reg(CFG_IDX_ON_CODE, 8'h80);
        send_idle_pct <= 68;
        make_random_items(PHASE_ITEMS);
        wait_idle();

        // ON code 127, writes to unlisted indexes, receiver stalling
        write_reg(CFG_IDX_IRQ_EN, 8'hFF);
        write_reg(CFG_IDX_ON_CODE, 8'hFF);
        write_reg(CFG_IDX_UNUSED_LO, 8'($urandom));
        write_reg(CFG_IDX_UNUSED_HI, 8'($urandom));
        send_idle_pct  <= 0;
        recv_stall_pct <= 68;
        make_random_items(PHASE_ITEMS);
        wait_idle();

        // ON code inside the matrix range
        write_reg(CFG_IDX_ON_CODE, 8'd10);
        send_idle_pct  <= 11;
        recv_stall_pct <= 11;
        make_random_items(PHASE_ITEMS);
        wait_idle();

        // full rate with one long receiver hold-off
        write_reg(CFG_IDX_ON_CODE, 8'd64);
        write_reg(CFG_IDX_IRQ_EN, 8'h01);
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        make_random_items(PHASE_ITEMS);
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        wait_idle();

        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* key_matrix_scanner_with_event_fifo.f */
src/kms_pkg.sv
src/kms_ram.sv
src/kms_datapath.sv
src/kms_ctrl.sv
src/key_matrix_scanner_with_event_fifo.sv
tb/key_matrix_scanner_with_event_fifo_tb.sv
